/* sv/rgb_to_luv_pixel_top_defines.svh */
// Assertion macros shared by the RGB to LUV pixel block.
// Used by rgb_to_luv_pixel_top; expects clk and arst_n in scope.
`ifndef RGB_TO_LUV_PIXEL_TOP_DEFINES_SVH
`define RGB_TO_LUV_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RGBLUV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define RGBLUV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/rgbluv_pkg.sv */
// Package for the RGB to LUV pixel block: types, constants, lightness ROM builder.
// No dependencies; used by every rgbluv module and the top level.
`default_nettype none
package rgbluv_pkg;

	localparam int LUT_DEPTH     = 1025;
	localparam int OUT_FRAC_BITS = 16;

	localparam int IDX_W = $clog2(LUT_DEPTH);
	localparam int XS_W  = 24;
	localparam int YS_W  = 25;
	localparam int ZS_W  = 25;
	localparam int S_W   = 29;
	localparam int Q_W   = 24;
	localparam int DIV_STAGES = Q_W;

	// Matrix rows, Q0.16 of coefficient/255 scaled back by 255
	localparam int unsigned XR = 28218;
	localparam int unsigned XG = 22384;
	localparam int unsigned XB = 11687;
	localparam int unsigned YR = 14550;
	localparam int unsigned YG = 46311;
	localparam int unsigned YB = 4675;
	localparam int unsigned ZR = 1323;
	localparam int unsigned ZG = 8490;
	localparam int unsigned ZB = 61550;

	localparam int unsigned Y_DEN  = 255 * 65536;
	localparam int IDX_SH = 25;
	localparam logic [63:0] IDX_MUL = (64'(LUT_DEPTH - 1) << IDX_SH) / Y_DEN;

	// last ROM index and the linear-segment denominator of the lightness curve
	localparam logic [63:0] ROM_LAST = 64'(LUT_DEPTH - 1);
	localparam logic [63:0] LIN_DEN  = 64'd7290 * ROM_LAST;
	localparam logic [63:0] LIN_HALF = 64'd3645 * ROM_LAST;

	localparam int unsigned TU_OFF = 13 * 3319087;
	localparam int unsigned TV_OFF = 13 * 7857290;

	localparam logic [63:0] OFF_U = ((64'd88 << (OUT_FRAC_BITS + 24)) + 64'd135) / 64'd270;
	localparam logic [63:0] OFF_V = ((64'd134 << (OUT_FRAC_BITS + 24)) + 64'd135) / 64'd270;
	localparam logic [63:0] ROUND24 = 64'd1 << 23;

	localparam logic [63:0] FULL_SCALE = (64'd1 << OUT_FRAC_BITS) - 64'd1;
	localparam logic [63:0] OUT_LIMIT  = (FULL_SCALE > 64'hFFFF) ? 64'hFFFF : FULL_SCALE;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [15:0] light;
		logic [15:0] chroma_u;
		logic [15:0] chroma_v;
	} luv_t;

	typedef struct packed {
		logic [XS_W-1:0]  xs;
		logic [YS_W-1:0]  ys;
		logic [S_W-1:0]   s;
		logic [IDX_W-1:0] q_est;
	} mat_t;

	typedef struct packed {
		logic [Q_W-1:0]   ru;
		logic [Q_W-1:0]   rv;
		logic [YS_W-1:0]  ys;
		logic [IDX_W-1:0] q_est;
	} div_t;

	typedef logic [OUT_FRAC_BITS-1:0] rom_t [LUT_DEPTH];

	function automatic logic [63:0] cube_root_floor(logic [63:0] t);
		logic [63:0] c;
		logic [63:0] cand;
		c = 64'd0;
		for (int b = 20; b >= 0; b--) begin
			cand = c | (64'd1 << b);
			if (cand * cand * cand <= t)
				c = cand;
		end
		return c;
	endfunction

	function automatic logic [63:0] light_entry(logic [63:0] idx);
		logic [63:0] c;
		logic [63:0] val;
		logic [63:0] res;
		if (idx * 64'd24389 > 64'd216 * ROM_LAST) begin
			c   = cube_root_floor((idx << 48) / ROM_LAST);
			val = 64'd116 * c - 64'd1048576;
			res = ((val << OUT_FRAC_BITS) + 64'd8847360) / 64'd17694720;
		end else begin
			res = (((idx * 64'd24389) << OUT_FRAC_BITS) + LIN_HALF) / LIN_DEN;
		end
		return res;
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < LUT_DEPTH; i++)
			r[i] = OUT_FRAC_BITS'(light_entry(64'(i)));
		return r;
	endfunction

	// round-shift a Q(F+24) chroma sum and clamp into the output range
	function automatic logic [15:0] sat_chroma(logic signed [50:0] sum);
		logic [26:0] r;
		r = 27'(sum >>> 24);
		if (sum < 0)
			return 16'd0;
		else if (64'(r) > OUT_LIMIT)
			return 16'(OUT_LIMIT);
		else
			return 16'(r);
	endfunction

endpackage
`default_nettype wire

/* sv/rgbluv_matrix.sv */
// Two stages: XYZ matrix products, then S sum and lightness index estimate.
// Depends on rgbluv_pkg.
`default_nettype none
module rgbluv_matrix (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire rgbluv_pkg::pixel_t in_pix,
	output logic                  out_valid,
	output rgbluv_pkg::mat_t      out_mat
);

	logic [31:0] r32, g32, b32;
	logic [rgbluv_pkg::XS_W-1:0] xs_c;
	logic [rgbluv_pkg::YS_W-1:0] ys_c;
	logic [rgbluv_pkg::ZS_W-1:0] zs_c;

	logic                        valid_s1, valid_s2;
	logic [rgbluv_pkg::XS_W-1:0] xs_s1;
	logic [rgbluv_pkg::YS_W-1:0] ys_s1;
	logic [rgbluv_pkg::ZS_W-1:0] zs_s1;
	rgbluv_pkg::mat_t            mat_s2;

	always_comb begin
		r32  = {24'd0, in_pix.red};
		g32  = {24'd0, in_pix.green};
		b32  = {24'd0, in_pix.blue};
		xs_c = rgbluv_pkg::XS_W'(r32 * 32'(rgbluv_pkg::XR) + g32 * 32'(rgbluv_pkg::XG)
			+ b32 * 32'(rgbluv_pkg::XB));
		ys_c = rgbluv_pkg::YS_W'(r32 * 32'(rgbluv_pkg::YR) + g32 * 32'(rgbluv_pkg::YG)
			+ b32 * 32'(rgbluv_pkg::YB));
		zs_c = rgbluv_pkg::ZS_W'(r32 * 32'(rgbluv_pkg::ZR) + g32 * 32'(rgbluv_pkg::ZG)
			+ b32 * 32'(rgbluv_pkg::ZB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s1        <= xs_c;
			ys_s1        <= ys_c;
			zs_s1        <= zs_c;
			mat_s2.xs    <= xs_s1;
			mat_s2.ys    <= ys_s1;
			mat_s2.s     <= rgbluv_pkg::S_W'(32'(xs_s1) + 32'(ys_s1) * 32'd15
				+ 32'(zs_s1) * 32'd3);
			// estimate is exact or one low; fixed up after the divider
			mat_s2.q_est <= rgbluv_pkg::IDX_W'((64'(ys_s1) * rgbluv_pkg::IDX_MUL)
				>> rgbluv_pkg::IDX_SH);
		end
	end

	assign out_valid = valid_s2;
	assign out_mat   = mat_s2;

endmodule
`default_nettype wire

/* sv/rgbluv_divider.sv */
// Pipelined restoring divider: X/S and Y/S in Q24, one quotient bit per stage.
// Depends on rgbluv_pkg.
`default_nettype none
module rgbluv_divider (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire rgbluv_pkg::mat_t in_mat,
	output logic                out_valid,
	output rgbluv_pkg::div_t    out_div
);

	localparam int N = rgbluv_pkg::DIV_STAGES;
	localparam int SW = rgbluv_pkg::S_W;
	localparam int QW = rgbluv_pkg::Q_W;

	logic                        valid_s [N+1];
	logic [SW-1:0]               rem_u_s [N+1];
	logic [SW-1:0]               rem_v_s [N+1];
	logic [QW-1:0]               quo_u_s [N+1];
	logic [QW-1:0]               quo_v_s [N+1];
	logic [SW-1:0]               den_s   [N+1];
	logic [rgbluv_pkg::YS_W-1:0] ys_s    [N+1];
	logic [rgbluv_pkg::IDX_W-1:0] qe_s   [N+1];

	// entry point; X < S whenever S is nonzero, so the first remainder fits
	always_comb begin
		valid_s[0] = in_valid;
		rem_u_s[0] = SW'(in_mat.xs);
		rem_v_s[0] = SW'(in_mat.ys);
		quo_u_s[0] = '0;
		quo_v_s[0] = '0;
		den_s[0]   = in_mat.s;
		ys_s[0]    = in_mat.ys;
		qe_s[0]    = in_mat.q_est;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [SW:0] sh_u, sh_v;
		logic        ge_u, ge_v;

		always_comb begin
			sh_u = {rem_u_s[k], 1'b0};
			sh_v = {rem_v_s[k], 1'b0};
			ge_u = sh_u >= {1'b0, den_s[k]};
			ge_v = sh_v >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[k+1] <= 1'b0;
			else if (en)
				valid_s[k+1] <= valid_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_u_s[k+1] <= ge_u ? SW'(sh_u - {1'b0, den_s[k]}) : SW'(sh_u);
				rem_v_s[k+1] <= ge_v ? SW'(sh_v - {1'b0, den_s[k]}) : SW'(sh_v);
				quo_u_s[k+1] <= {quo_u_s[k][QW-2:0], ge_u};
				quo_v_s[k+1] <= {quo_v_s[k][QW-2:0], ge_v};
				den_s[k+1]   <= den_s[k];
				ys_s[k+1]    <= ys_s[k];
				qe_s[k+1]    <= qe_s[k];
			end
		end
	end

	// black pixel: S is zero, ratios forced to zero
	always_comb begin
		out_valid     = valid_s[N];
		out_div.ru    = (den_s[N] == '0) ? '0 : quo_u_s[N];
		out_div.rv    = (den_s[N] == '0) ? '0 : quo_v_s[N];
		out_div.ys    = ys_s[N];
		out_div.q_est = qe_s[N];
	end

endmodule
`default_nettype wire

/* sv/rgbluv_chroma.sv */
// Four stages: index fix-up and chroma terms, lightness ROM, products, offset and clamp.
// Depends on rgbluv_pkg.
`default_nettype none
module rgbluv_chroma (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire rgbluv_pkg::div_t in_div,
	output logic                out_valid,
	output rgbluv_pkg::luv_t    out_luv
);

	localparam int IW = rgbluv_pkg::IDX_W;
	localparam rgbluv_pkg::rom_t LIGHT_ROM = rgbluv_pkg::build_rom();

	logic [47:0]   num_c, base_c, rest_c;
	logic [IW:0]   idx_inc_c;
	logic [IW-1:0] idx_c;
	logic signed [31:0] tu_c, tv_c;
	logic [rgbluv_pkg::OUT_FRAC_BITS-1:0] light_c;
	logic signed [50:0] sum_u_c, sum_v_c;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic [IW-1:0] idx_s1;
	logic signed [31:0] tu_s1, tv_s1, tu_s2, tv_s2;
	logic [rgbluv_pkg::OUT_FRAC_BITS-1:0] raw_s2;
	logic [15:0] light_s3;
	logic signed [48:0] prod_u_s3, prod_v_s3;
	rgbluv_pkg::luv_t luv_s4;

	always_comb begin
		num_c     = 48'(in_div.ys) * 48'(rgbluv_pkg::LUT_DEPTH - 1);
		base_c    = 48'(in_div.q_est) * 48'(rgbluv_pkg::Y_DEN);
		rest_c    = num_c - base_c;
		idx_inc_c = {1'b0, in_div.q_est} + ((rest_c >= 48'(rgbluv_pkg::Y_DEN)) ? 1'b1 : 1'b0);
		if (idx_inc_c > (IW+1)'(rgbluv_pkg::LUT_DEPTH - 1))
			idx_c = IW'(rgbluv_pkg::LUT_DEPTH - 1);
		else
			idx_c = idx_inc_c[IW-1:0];
		tu_c = signed'(32'(in_div.ru) * 32'd52 - 32'(rgbluv_pkg::TU_OFF));
		tv_c = signed'(32'(in_div.rv) * 32'd117 - 32'(rgbluv_pkg::TV_OFF));
	end

	always_comb begin
		if (64'(raw_s2) > rgbluv_pkg::OUT_LIMIT)
			light_c = rgbluv_pkg::OUT_FRAC_BITS'(rgbluv_pkg::OUT_LIMIT);
		else
			light_c = raw_s2;
		sum_u_c = 51'(prod_u_s3) + signed'(51'(rgbluv_pkg::OFF_U + rgbluv_pkg::ROUND24));
		sum_v_c = 51'(prod_v_s3) + signed'(51'(rgbluv_pkg::OFF_V + rgbluv_pkg::ROUND24));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1           <= idx_c;
			tu_s1            <= tu_c;
			tv_s1            <= tv_c;
			raw_s2           <= LIGHT_ROM[idx_s1];
			tu_s2            <= tu_s1;
			tv_s2            <= tv_s1;
			light_s3         <= 16'(light_c);
			prod_u_s3        <= signed'({1'b0, 16'(light_c)}) * tu_s2;
			prod_v_s3        <= signed'({1'b0, 16'(light_c)}) * tv_s2;
			luv_s4.light     <= light_s3;
			luv_s4.chroma_u  <= rgbluv_pkg::sat_chroma(sum_u_c);
			luv_s4.chroma_v  <= rgbluv_pkg::sat_chroma(sum_v_c);
		end
	end

	assign out_valid = valid_s4;
	assign out_luv   = luv_s4;

endmodule
`default_nettype wire

/* sv/rgb_to_luv_pixel_top.sv */
// Top level of the RGB to normalized CIE LUV pixel converter.
// Depends on rgbluv_pkg, rgbluv_matrix, rgbluv_divider, rgbluv_chroma and the defines header.
//
// One pixel in, one LUV result out, one transaction per clock sustained while
// luv_stall is low. The path is a 30-stage pipeline: 2 stages for the XYZ
// matrix and S sum, 24 stages of a restoring divider (one Q24 quotient bit
// each) for X/S and Y/S, and 4 stages for the lightness index fix-up, the
// registered lightness ROM read, the chroma products and the offset/clamp.
// An accepted pixel passes the 30 stages and the output register before its
// result is offered, later only while the output is stalled. A skid register
// behind the output register takes the one transaction still in flight when
// luv_stall rises; pix_stall follows the skid register, so it rises in the
// cycle after the output backs up. A black pixel gives light 0 and the bare
// chroma offsets. There is no state between pixels and no configuration.
`default_nettype none
`include "rgb_to_luv_pixel_top_defines.svh"
module rgb_to_luv_pixel_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pix_valid,
	output logic                    pix_stall,
	input  wire rgbluv_pkg::pixel_t pix,
	output logic                    luv_valid,
	input  wire logic               luv_stall,
	output rgbluv_pkg::luv_t        luv
);

	logic             pipe_en;
	logic             mat_valid, div_valid, p_valid;
	rgbluv_pkg::mat_t mat;
	rgbluv_pkg::div_t dv;
	rgbluv_pkg::luv_t p_luv;

	logic             luv_valid_q, skid_valid_q;
	rgbluv_pkg::luv_t luv_q, skid_q;

	// whole pipeline moves unless the skid register holds a transaction
	assign pipe_en   = !skid_valid_q;
	assign pix_stall = skid_valid_q;

	rgbluv_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (pix_valid),
		.in_pix    (pix),
		.out_valid (mat_valid),
		.out_mat   (mat)
	);

	rgbluv_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (mat_valid),
		.in_mat    (mat),
		.out_valid (div_valid),
		.out_div   (dv)
	);

	rgbluv_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (div_valid),
		.in_div    (dv),
		.out_valid (p_valid),
		.out_luv   (p_luv)
	);

	// output register with skid: skid drains first, else take the pipeline tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luv_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!luv_valid_q || !luv_stall) begin
			luv_valid_q  <= skid_valid_q || p_valid;
			skid_valid_q <= 1'b0;
		end else if (p_valid && pipe_en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!luv_valid_q || !luv_stall) begin
			luv_q <= skid_valid_q ? skid_q : p_luv;
		end else if (p_valid && pipe_en) begin
			skid_q <= p_luv;
		end
	end

	assign luv_valid = luv_valid_q;
	assign luv       = luv_q;

	// a held skid entry implies a pending output transaction
	`RGBLUV_ASSERT_NOW(a_skid_implies_out, skid_valid_q, luv_valid_q, "skid full with output empty")
	// once output is released, a skid entry must show up as output next cycle
	`RGBLUV_ASSERT_NEXT(a_skid_drains, skid_valid_q && !luv_stall, luv_valid_q, "skid entry lost")
	// lightness never exceeds the saturation limit
	`RGBLUV_ASSERT_NOW(a_light_limit, luv_valid_q, 64'(luv_q.light) <= rgbluv_pkg::OUT_LIMIT, "light above limit")

endmodule
`default_nettype wire

/* tb/sv/rgb_to_luv_pixel_checker.sv */
// Watches both pixel channels of the RGB to LUV block, predicts each LUV result
// and compares it field by field. Depends on rgbluv_pkg for the payload types.
module rgb_to_luv_pixel_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pix_valid,
	input  wire logic               pix_stall,
	input  wire rgbluv_pkg::pixel_t pix,
	input  wire logic               luv_valid,
	input  wire logic               luv_stall,
	input  wire rgbluv_pkg::luv_t   luv,
	output int                      fail_count,
	output int                      pending_count,
	output int                      result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import rgbluv_pkg::*;

	localparam longint unsigned ROM_LAST = 1024;
	localparam longint unsigned LIM = 65535;

	luv_t luv_expected [$];
	logic [15:0] light_table [0:1024];

	function automatic longint unsigned icbrt(longint unsigned t);
		longint unsigned c, cand;
		c = 0;
		for (int b = 20; b >= 0; b--) begin
			cand = c | (64'd1 << b);
			if (cand * cand * cand <= t)
				c = cand;
		end
		return c;
	endfunction

	function automatic logic [15:0] chroma_out(longint unsigned l, longint signed term,
			longint unsigned offs);
		longint signed acc;
		longint unsigned q;
		acc = longint'(l) * term + longint'(offs) + (64'sd1 <<< 23);
		if (acc < 0)
			return 16'd0;
		q = longint'(acc) >> 24;
		return (q > LIM) ? 16'(LIM) : 16'(q);
	endfunction

	function automatic luv_t convert_pixel(pixel_t p);
		longint unsigned b, g, r, xs, ys, zs, s, idx, l, ru, rv, off_u, off_v;
		luv_t o;
		b = p.blue; g = p.green; r = p.red;
		xs = 28218 * r + 22384 * g + 11687 * b;
		ys = 14550 * r + 46311 * g + 4675 * b;
		zs = 1323 * r + 8490 * g + 61550 * b;
		s = xs + 15 * ys + 3 * zs;
		idx = (ys * ROM_LAST) / (255 * 65536);
		if (idx > ROM_LAST)
			idx = ROM_LAST;
		l = light_table[idx];
		ru = 0; rv = 0;
		if (s != 0) begin
			ru = (xs << 24) / s;
			rv = (ys << 24) / s;
		end
		off_u = ((64'd88 << 40) + 135) / 270;
		off_v = ((64'd134 << 40) + 135) / 270;
		o.light = 16'(l);
		o.chroma_u = chroma_out(l, 52 * longint'(ru) - 13 * 3319087, off_u);
		o.chroma_v = chroma_out(l, 117 * longint'(rv) - 13 * 7857290, off_v);
		return o;
	endfunction

	initial begin
		longint unsigned c, v;
		for (longint unsigned i = 0; i <= ROM_LAST; i++) begin
			if (i * 24389 > 216 * ROM_LAST) begin
				c = icbrt((i << 48) / ROM_LAST);
				v = 116 * c - 16 * 65536;
				v = ((v << 16) + 8847360) / 17694720;
			end else
				v = (((i * 24389) << 16) + 3645 * ROM_LAST) / (7290 * ROM_LAST);
			light_table[i] = (v > LIM) ? 16'(LIM) : 16'(v);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		luv_t e;
		int   errs;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
			pending_count <= 0;
		end else begin
			errs = 0;
			if (pix_valid && !pix_stall)
				luv_expected.push_back(convert_pixel(pix));
			if (luv_valid && !luv_stall) begin
				result_count <= result_count + 1;
				if (luv_expected.size() == 0) begin
					$error("unexpected LUV transaction %h", luv);
					errs++;
				end else begin
					e = luv_expected.pop_front();
					if (luv.light !== e.light) begin
						$error("light: expected %h actual %h", e.light, luv.light);
						errs++;
					end
					if (luv.chroma_u !== e.chroma_u) begin
						$error("chroma_u: expected %h actual %h", e.chroma_u, luv.chroma_u);
						errs++;
					end
					if (luv.chroma_v !== e.chroma_v) begin
						$error("chroma_v: expected %h actual %h", e.chroma_v, luv.chroma_v);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= luv_expected.size();
		end
	end
endmodule

/* tb/sv/rgb_to_luv_pixel_top_test.sv */
// Top of the RGB to LUV pixel testbench: clock, reset, pixel stimulus, output stall.
// Depends on rgbluv_pkg, rgb_to_luv_pixel_top and rgb_to_luv_pixel_checker.
module rgb_to_luv_pixel_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbluv_pkg::*;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   pix_valid = 1'b0;
	logic   pix_stall;
	pixel_t pix = '0;
	logic   luv_valid;
	logic   luv_stall = 1'b0;
	luv_t   luv;
	int     fail_count, pending_count, result_count;
	int     pixels_sent = 0;
	bit     stall_quiet = 1'b0;   // output stall generator pauses during the quiet stretch

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rgb_to_luv_pixel_top dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.luv_valid(luv_valid), .luv_stall(luv_stall), .luv(luv)
	);

	rgb_to_luv_pixel_checker chk (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.luv_valid(luv_valid), .luv_stall(luv_stall), .luv(luv),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one pixel and hold it until the transaction completes; valid stays
	// high across back-to-back pixels, so it is only lowered for a real gap
	task automatic send_pixel(pixel_t p, int gap);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		pixels_sent++;
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		int kind;
		kind = $urandom_range(0, 9);
		p.blue = 8'($urandom);
		p.green = 8'($urandom);
		p.red = 8'($urandom);
		// bias toward dark and saturated corners where L and chroma clamp
		if (kind == 0) p = '0;
		else if (kind == 1) p = '{8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
			8'($urandom_range(0, 3))};
		else if (kind == 2) p.green = 8'd255;
		else if (kind == 3) p.red = 8'($urandom_range(250, 255));
		return p;
	endfunction

	// output stall: random stretches, with a quiet stretch during the directed part
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_quiet)
				luv_stall <= 1'b0;
			else if ($urandom_range(0, 99) < 3) begin
				luv_stall <= 1'b1;
				repeat ($urandom_range(5, 40)) @(posedge clk);
			end else
				luv_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	initial begin
		pixel_t directed [$];
		int     wait_cycles;
		directed = '{
			'{8'd0, 8'd0, 8'd0},         // black: bare offsets
			'{8'd255, 8'd255, 8'd255},   // white: top index of the lightness ROM
			'{8'd255, 8'd0, 8'd0},       // pure blue
			'{8'd0, 8'd255, 8'd0},       // pure green
			'{8'd0, 8'd0, 8'd255},       // pure red
			'{8'd1, 8'd0, 8'd0},         // smallest nonzero sums, linear part of L
			'{8'd0, 8'd1, 8'd0},
			'{8'd0, 8'd0, 8'd1},
			'{8'd255, 8'd255, 8'd0},
			'{8'd0, 8'd255, 8'd255},
			'{8'd255, 8'd0, 8'd255},
			'{8'd170, 8'd85, 8'd170},    // alternating bit patterns
			'{8'd85, 8'd170, 8'd85},
			'{8'd10, 8'd10, 8'd10},      // low grays, above the cube-root knee of L
			'{8'd20, 8'd20, 8'd20},
			'{8'd128, 8'd128, 8'd128},
			'{8'd254, 8'd254, 8'd254}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_quiet = 1'b1;
		foreach (directed[i])
			send_pixel(directed[i], 0);
		stall_quiet = 1'b0;
		foreach (directed[i])
			send_pixel(directed[i], pick_gap());

		for (int n = 0; n < 820; n++)
			send_pixel(rand_pixel(), (n % 200 < 40) ? 0 : pick_gap());
		pix_valid <= 1'b0;

		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);

		$display("Sent %0d pixels (directed corners, black, white, primaries, then random",
			pixels_sent);
		$display("  with gaps and output stalls); %0d LUV results checked.", result_count);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
